// ===== rtl/slfb_pkg.sv =====
package slfb_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        CMD_READ = 2'd0,
        CMD_WR4  = 2'd1,
        CMD_WR8  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    localparam int IDX_W  = 5;   // frame position, up to 17
    localparam int NDIG_W = 4;   // data digit count: 0, 4 or 8

    localparam logic [7:0] SOH_BYTE    = 8'h01;
    localparam logic [7:0] STX_BYTE    = 8'h02;
    localparam logic [7:0] ETX_BYTE    = 8'h03;
    localparam logic [7:0] DIGIT_BASE  = 8'h30;
    localparam logic [7:0] LETTER_BASE = 8'h41;

    localparam logic [NDIG_W-1:0] NDIG_RD  = 4'd0;
    localparam logic [NDIG_W-1:0] NDIG_WR4 = 4'd4;
    localparam logic [NDIG_W-1:0] NDIG_WR8 = 4'd8;

    // Fixed positions in the frame
    localparam logic [IDX_W-1:0] POS_SOH     = 5'd0;
    localparam logic [IDX_W-1:0] POS_STATION = 5'd1;
    localparam logic [IDX_W-1:0] POS_CODE_HI = 5'd2;
    localparam logic [IDX_W-1:0] POS_CODE_LO = 5'd3;
    localparam logic [IDX_W-1:0] POS_STX     = 5'd4;
    localparam logic [IDX_W-1:0] POS_DNUM_HI = 5'd5;
    localparam logic [IDX_W-1:0] POS_DNUM_LO = 5'd6;
    localparam logic [IDX_W-1:0] POS_DATA    = 5'd7;

    // Position and frame shape handed to the byte selector
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [NDIG_W-1:0] ndig;
    } t_frame_ctl;

    // What the selector says about the current byte
    typedef struct packed {
        logic counted;   // goes into the checksum
        logic is_data;   // a data digit: advance the data shifter
        logic last;      // final checksum digit
    } t_byte_info;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_digit = DIGIT_BASE + ext;
        end else begin
            hex_digit = LETTER_BASE + ext - 8'd10;
        end
    endfunction

endpackage

// ===== rtl/slfb_byte_sel.sv =====
module slfb_byte_sel (
    input  slfb_pkg::t_frame_ctl i_ctl,
    input  logic [3:0]           i_station,
    input  logic [7:0]           i_command_code,
    input  logic [7:0]           i_data_number,
    input  logic [3:0]           i_data_nibble,
    input  logic [7:0]           i_sum,
    output logic [7:0]           o_byte,
    output slfb_pkg::t_byte_info o_info
);
    import slfb_pkg::*;

    logic [IDX_W-1:0] pos_etx;
    logic [IDX_W-1:0] pos_cs_hi;
    logic [IDX_W-1:0] pos_cs_lo;

    assign pos_etx   = POS_DATA + {1'b0, i_ctl.ndig};
    assign pos_cs_hi = pos_etx + 5'd1;
    assign pos_cs_lo = pos_etx + 5'd2;

    always_comb begin
        o_byte         = ETX_BYTE;
        o_info.counted = 1'b0;
        o_info.is_data = 1'b0;
        o_info.last    = 1'b0;
        case (i_ctl.idx)
            POS_SOH:     o_byte = SOH_BYTE;
            POS_STATION: o_byte = hex_digit(i_station);
            POS_CODE_HI: o_byte = hex_digit(i_command_code[7:4]);
            POS_CODE_LO: o_byte = hex_digit(i_command_code[3:0]);
            POS_STX:     o_byte = STX_BYTE;
            POS_DNUM_HI: o_byte = hex_digit(i_data_number[7:4]);
            POS_DNUM_LO: o_byte = hex_digit(i_data_number[3:0]);
            default: begin
                if (i_ctl.idx < pos_etx) begin
                    o_byte         = hex_digit(i_data_nibble);
                    o_info.is_data = 1'b1;
                end else if (i_ctl.idx == pos_etx) begin
                    o_byte = ETX_BYTE;
                end else if (i_ctl.idx == pos_cs_hi) begin
                    o_byte = hex_digit(i_sum[7:4]);
                end else begin
                    o_byte = hex_digit(i_sum[3:0]);
                end
            end
        endcase
        // everything from the station digit through ETX is summed
        if (i_ctl.idx != POS_SOH && i_ctl.idx <= pos_etx) begin
            o_info.counted = 1'b1;
        end
        if (i_ctl.idx == pos_cs_lo) begin
            o_info.last = 1'b1;
        end
    end

endmodule

// ===== rtl/servo_link_frame_builder.sv =====
// Serial command frame builder: ASCII hex fields with an 8-bit sum check.
//
// Request side: a transaction is taken on a rising edge with start high
// and busy low. i_cmd picks a read frame (10 bytes), a 4-digit write
// (14 bytes) or an 8-digit write (18 bytes); the unused code is taken
// and dropped with no output.
// Result side: one frame byte per cycle on o_frame_byte, flagged by
// o_strobe for exactly one cycle each; o_last_byte marks the second
// checksum digit. The receiver has no way to stall, so bytes stream out
// back to back.
// The SOH byte reaches the result ports through the request register,
// then the result register, once the request is taken.
// Throughput: one byte per cycle; a request sends 10, 14 or 18 bytes,
// as i_cmd picks. busy drops while the final checksum
// digit sits in the request register, so a request waiting on start is
// taken then and its SOH follows the last checksum digit with no gap.
// Reset (synchronous, active low) drops any frame in flight and clears
// the strobe; the block then idles with busy low.
module servo_link_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_station,
    input  logic [7:0]  i_command_code,
    input  logic [7:0]  i_data_number,
    input  logic [31:0] i_data_value,
    output logic        o_strobe,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);
    import slfb_pkg::*;

    // Request register
    logic              r_active;
    logic [IDX_W-1:0]  r_idx;
    logic [NDIG_W-1:0] r_ndig;
    logic [3:0]        r_station;
    logic [7:0]        r_code;
    logic [7:0]        r_dnum;
    logic [31:0]       r_data;     // data digits, next one in the top nibble
    logic [7:0]        r_sum;      // running checksum

    // Result register
    logic              r_strobe;
    logic [7:0]        r_byte;
    logic              r_last;

    logic              n_active;
    logic [IDX_W-1:0]  n_idx;
    logic [NDIG_W-1:0] n_ndig;
    logic [31:0]       n_data;
    logic [7:0]        n_sum;

    t_frame_ctl ctl;
    t_byte_info info;
    logic [7:0] cur_byte;
    logic       take;
    t_cmd       req_cmd;

    assign ctl.idx  = r_idx;
    assign ctl.ndig = r_ndig;

    slfb_byte_sel u_sel (
        .i_ctl          (ctl),
        .i_station      (r_station),
        .i_command_code (r_code),
        .i_data_number  (r_dnum),
        .i_data_nibble  (r_data[31:28]),
        .i_sum          (r_sum),
        .o_byte         (cur_byte),
        .o_info         (info)
    );

    // free during the last byte so the next frame follows without a gap
    assign busy    = r_active && !info.last;
    assign take    = start && !busy;
    assign req_cmd = t_cmd'(i_cmd);

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        n_ndig   = r_ndig;
        n_data   = r_data;
        n_sum    = r_sum;
        if (r_active) begin
            n_idx = r_idx + 5'd1;
            if (info.counted) begin
                n_sum = r_sum + cur_byte;
            end
            if (info.is_data) begin
                n_data = {r_data[27:0], 4'h0};
            end
            if (info.last) begin
                n_active = 1'b0;
            end
        end
        if (take) begin
            n_idx    = POS_SOH;
            n_sum    = 8'h00;
            n_active = 1'b1;
            case (req_cmd)
                CMD_READ: begin
                    n_ndig = NDIG_RD;
                    n_data = i_data_value;
                end
                CMD_WR4: begin
                    n_ndig = NDIG_WR4;
                    n_data = {i_data_value[15:0], 16'h0000};
                end
                CMD_WR8: begin
                    n_ndig = NDIG_WR8;
                    n_data = i_data_value;
                end
                default: begin
                    // unused code: taken, nothing sent
                    n_ndig   = NDIG_RD;
                    n_data   = i_data_value;
                    n_active = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_strobe <= r_active;
            r_last   <= r_active && info.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_ndig <= n_ndig;
        r_data <= n_data;
        r_sum  <= n_sum;
        r_byte <= cur_byte;
        if (take) begin
            r_station <= i_station;
            r_code    <= i_command_code;
            r_dnum    <= i_data_number;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

`ifndef SYNTH
    // last-byte flag only ever rides on a strobed byte
    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_byte |-> o_strobe)
        else $error("last flag without strobe");

    // a taken request with a real command puts SOH out through the request and result registers
    a_soh_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd != CMD_NONE) |=> ##1 (o_strobe && o_frame_byte == SOH_BYTE))
        else $error("frame did not open with SOH");

    // bytes of one frame are contiguous until the last one
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_byte) |=> o_strobe)
        else $error("gap inside a frame");

    // frame never runs past the long-write length
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx <= (POS_DATA + 5'd10)))
        else $error("frame position out of range");
`endif

endmodule
